// ===== hdl/i2c_master_bit_engine_unit_macros.svh =====
// Assertion macros for the I2C master bit engine.
// Used by the top level; needs a clock and an active-high reset at the call site.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTH
// Clocked check, off while reset is high
`define I2CBE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("i2cbe assertion failed");
// Clocked check that also holds during reset
`define I2CBE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("i2cbe assertion failed");
`else
`define I2CBE_ASSERT(label, clk, rst, prop)
`define I2CBE_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hdl/i2cbe_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// No dependencies.
`default_nettype none

package i2cbe_pkg;

   // Command phase; codes match the request action field
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_START = 3'd1,
      PH_STOP  = 3'd2,
      PH_WRITE = 3'd3,
      PH_READ  = 3'd4
   } phase_type;

   // Request action codes
   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_START = 3'd1;
   localparam logic [2:0] ACT_STOP  = 3'd2;
   localparam logic [2:0] ACT_WRITE = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   // Register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUARTER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MSB     = 1'b1;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_DATA_W-1:0] QUARTER_RESET = 16'd100;

   // Slots per command (quarter-bit units)
   localparam logic [5:0] SLOTS_START = 6'd3;
   localparam logic [5:0] SLOTS_STOP  = 6'd6;
   localparam logic [5:0] SLOTS_BYTE  = 6'd36;
   localparam logic [3:0] LAST_DATA_BIT = 4'd7;

   localparam int unsigned TICK_COUNT_WIDTH_DEF = 16;

endpackage

`default_nettype wire

// ===== hdl/i2c_master_bit_engine_unit.sv =====
// I2C master bit engine: quarter-slot prescaler, command sequencer, shift register.
// Depends on i2cbe_pkg and i2c_master_bit_engine_unit_macros.svh.
// Response is registered: valid in the cycle after its request transfers.
// One request per cycle, set by the response register: a new tick is taken
// whenever the response slot is empty or is being taken in the same cycle.
// Reset (synchronous, active high) clears to idle with SCL/SDA high and driven.
`default_nettype none

`include "i2c_master_bit_engine_unit_macros.svh"

module i2c_master_bit_engine_unit #(
   parameter int unsigned TICK_COUNT_WIDTH = i2cbe_pkg::TICK_COUNT_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [2:0]                         req_action,
   input  wire logic [7:0]                         req_tx_byte,
   input  wire logic                               req_send_nack,
   input  wire logic                               req_sda_sample,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_scl_level,
   output logic                                    rsp_sda_level,
   output logic                                    rsp_sda_drive,
   output logic                                    rsp_busy_res,
   output logic                                    rsp_done_res,
   output logic [7:0]                              rsp_rx_byte,
   output logic                                    rsp_nack_seen,
   // configuration
   input  wire logic                               csr_we,
   input  wire logic [i2cbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [i2cbe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import i2cbe_pkg::*;

   localparam int unsigned CW   = TICK_COUNT_WIDTH;
   localparam int unsigned LIMW = ((CW > CSR_DATA_W) ? CW : CSR_DATA_W) + 1;

   // Registers
   logic [CSR_DATA_W-1:0] quarter_ff;
   logic                  msb_ff;
   phase_type             phase_ff, phase_in;
   logic [5:0]            slot_ff, slot_in;
   logic [CW-1:0]         tick_ff, tick_in;
   logic [7:0]            shift_ff, shift_in;
   logic [7:0]            rx_ff, rx_in;
   logic                  nack_ff, nack_in;
   logic                  pend_ff, pend_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic                  en_ff, en_in;
   logic                  done_ff, done_in;
   logic                  rsp_valid_ff;

   logic                  req_fire;
   logic                  cmd_ok;
   logic [LIMW-1:0]       cnt_inc, limit, cap;
   logic                  hit;
   logic [5:0]            g_adv, total;
   logic                  last;
   logic                  enter;
   logic [5:0]            g;
   phase_type             ph_e;
   logic [3:0]            bit_i;
   logic [1:0]            q;

   // Handshake: response register frees when empty or being taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   assign cmd_ok = (req_action == ACT_START) || (req_action == ACT_STOP) ||
                   (req_action == ACT_WRITE) || (req_action == ACT_READ);

   // Prescaler: quarter of zero acts as one, counter overflow caps the quarter
   always_comb begin
      cnt_inc = LIMW'(tick_ff) + LIMW'(1);
      limit   = (quarter_ff == '0) ? LIMW'(1) : LIMW'(quarter_ff);
      cap     = LIMW'(1) << CW;
      hit     = (cnt_inc >= limit) || (cnt_inc == cap);
      g_adv   = slot_ff + 6'd1;
      unique case (phase_ff)
         PH_START: total = SLOTS_START;
         PH_STOP:  total = SLOTS_STOP;
         default:  total = SLOTS_BYTE;
      endcase
      last = hit && (g_adv >= total);
   end

   // Phase next state
   always_comb begin
      phase_in = phase_ff;
      if (phase_ff == PH_IDLE) begin
         if (cmd_ok) begin
            phase_in = phase_type'(req_action);
         end
      end else if (last) begin
         phase_in = PH_IDLE;
      end
   end

   // Datapath: slot entry actions and command completion
   always_comb begin
      slot_in  = slot_ff;
      tick_in  = tick_ff;
      shift_in = shift_ff;
      rx_in    = rx_ff;
      nack_in  = nack_ff;
      pend_in  = pend_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      en_in    = en_ff;
      done_in  = 1'b0;
      enter    = 1'b0;
      g        = 6'd0;
      ph_e     = phase_in;

      if (phase_ff == PH_IDLE) begin
         if (cmd_ok) begin
            slot_in = 6'd0;
            tick_in = '0;
            enter   = 1'b1;
            if (req_action == ACT_WRITE) begin
               shift_in = req_tx_byte;
               pend_in  = 1'b0;
            end else if (req_action == ACT_READ) begin
               shift_in = 8'd0;
               pend_in  = req_send_nack;
            end
         end
      end else if (hit) begin
         tick_in = '0;
         if (last) begin
            if (phase_ff == PH_WRITE) nack_in = pend_ff;
            if (phase_ff == PH_READ)  rx_in   = shift_ff;
            slot_in = 6'd0;
            done_in = 1'b1;
         end else begin
            slot_in = g_adv;
            g       = g_adv;
            enter   = 1'b1;
         end
      end else begin
         tick_in = cnt_inc[CW-1:0];
      end

      bit_i = g[5:2];
      q     = g[1:0];

      if (enter) begin
         unique case (ph_e)
            PH_START: begin
               if (g == 6'd0) begin
                  en_in  = 1'b1;
                  scl_in = 1'b1;
                  sda_in = 1'b1;
               end else if (g == 6'd1) begin
                  sda_in = 1'b0;
               end else begin
                  scl_in = 1'b0;
               end
            end
            PH_STOP: begin
               if (g == 6'd0) begin
                  en_in  = 1'b1;
                  sda_in = 1'b0;
               end else if (g == 6'd2) begin
                  scl_in = 1'b1;
               end else if (g == 6'd4) begin
                  sda_in = 1'b1;
               end
            end
            PH_WRITE, PH_READ: begin
               unique case (q)
                  2'd0: begin
                     scl_in = 1'b0;
                     if (ph_e == PH_WRITE) begin
                        if (bit_i <= LAST_DATA_BIT) begin
                           en_in = 1'b1;
                           if (msb_ff) begin
                              sda_in   = shift_in[7];
                              shift_in = {shift_in[6:0], 1'b0};
                           end else begin
                              sda_in   = shift_in[0];
                              shift_in = {1'b0, shift_in[7:1]};
                           end
                        end else begin
                           sda_in = 1'b1;
                           en_in  = 1'b0;
                        end
                     end else begin
                        if (bit_i <= LAST_DATA_BIT) begin
                           en_in = 1'b0;
                        end else begin
                           en_in  = 1'b1;
                           sda_in = pend_in;
                        end
                     end
                  end
                  2'd1: begin
                     scl_in = 1'b1;
                     if (ph_e == PH_WRITE && bit_i > LAST_DATA_BIT) begin
                        pend_in = req_sda_sample;
                     end else if (ph_e == PH_READ && bit_i <= LAST_DATA_BIT) begin
                        if (msb_ff) shift_in = {shift_in[6:0], req_sda_sample};
                        else        shift_in = {req_sda_sample, shift_in[7:1]};
                     end
                  end
                  2'd3: begin
                     // second ACK sample at end of SCL high
                     if (ph_e == PH_WRITE && bit_i > LAST_DATA_BIT && pend_in) begin
                        pend_in = req_sda_sample;
                     end
                     scl_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ff <= QUARTER_RESET;
         msb_ff     <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUARTER: quarter_ff <= csr_wdata;
            CSR_MSB:     msb_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Engine state; doubles as the response payload register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         slot_ff  <= 6'd0;
         tick_ff  <= '0;
         shift_ff <= 8'd0;
         rx_ff    <= 8'd0;
         nack_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         en_ff    <= 1'b1;
         done_ff  <= 1'b0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         tick_ff  <= tick_in;
         shift_ff <= shift_in;
         rx_ff    <= rx_in;
         nack_ff  <= nack_in;
         pend_ff  <= pend_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         en_ff    <= en_in;
         done_ff  <= done_in;
      end
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = scl_ff;
   assign rsp_sda_level = sda_ff;
   assign rsp_sda_drive = en_ff;
   assign rsp_busy_res  = (phase_ff != PH_IDLE);
   assign rsp_done_res  = done_ff;
   assign rsp_rx_byte   = rx_ff;
   assign rsp_nack_seen = nack_ff;

   // Checks
   `I2CBE_ASSERT(a_done_idle, clock, reset, done_ff |-> (phase_ff == PH_IDLE))
   `I2CBE_ASSERT(a_slot_range, clock, reset, slot_ff < SLOTS_BYTE)
   `I2CBE_ASSERT(a_noop_idle, clock, reset,
      (req_fire && phase_ff == PH_IDLE && req_action == ACT_NONE) |=> (phase_ff == PH_IDLE))
   `I2CBE_ASSERT(a_rx_on_done, clock, reset, $stable(rx_ff) || done_ff)
   `I2CBE_ASSERT_ALWAYS(a_idle_slot_zero, clock, (phase_ff == PH_IDLE) |-> (slot_ff == 6'd0))

endmodule

`default_nettype wire
